### rtl/core/elas_pkg.sv
// Shared types, register indexes and the arctangent table for the edge length unit.
`timescale 1ns / 1ps

package elas_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 14;
    localparam int SPEED_W = 14;
    localparam int WALK_W = 10;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MOTORWAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIMARY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECONDARY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESIDENTIAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WALKING = 3'd4;

    typedef struct packed {
        logic [SPEED_W-1:0] car_speed;
        logic [WALK_W-1:0]  foot_speed;
        logic [1:0]         access;
    } side_t;

    // one classified edge as it sits in the queue
    typedef struct packed {
        logic [27:0] lat1_mag;
        logic [27:0] lat2_mag;
        logic [27:0] dlat_mag;
        logic [29:0] dlon;
        side_t       side;
    } item_t;

    // atan(2^-i) in Q30
    function automatic logic [30:0] atan_q30(input int unsigned i);
        logic [30:0] v;
        case (i)
            0: v = 31'd843314857;
            1: v = 31'h1DAC6705;
            2: v = 31'h0FADBAFC;
            3: v = 31'h07F56EA6;
            4: v = 31'h03FEAB76;
            5: v = 31'h01FFD55B;
            6: v = 31'h00FFFAAA;
            7: v = 31'h007FFF55;
            8: v = 31'h003FFFEA;
            9: v = 31'h001FFFFD;
            10: v = 31'd1048576;
            default:
            begin
                if (i <= 30)
                    v = 31'd1 << (30 - i);
                else
                    v = '0;
            end
        endcase
        return v;
    endfunction

endpackage

### rtl/core/edge_length_and_speed_unit.sv
// Top level of the edge length and speed unit.
`timescale 1ns / 1ps

// Takes one road edge per clock: start is taken whenever busy is low, and busy
// rises only if the queue fills, which the free-running back end does not allow.
// Each edge gives one result, shown for one cycle with done high, in order,
// produced by the three-stage reciprocal angle conversion, the rotation CORDIC,
// the 31-stage square roots and the vectoring CORDIC, all fully pipelined.
// The receiver cannot hold results off. Configuration writes (cfg_ready is
// always high) should only be made while no edge is in flight.
module edge_length_and_speed_unit #(
    parameter int CORDIC_STEPS = 28
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [27:0]                start_lat_udeg,
    input  logic signed [28:0]                start_lon_udeg,
    input  logic signed [27:0]                end_lat_udeg,
    input  logic signed [28:0]                end_lon_udeg,
    input  logic [3:0]                        road_kind,
    input  logic                              car_allowed,
    input  logic                              foot_allowed,
    output logic                              done,
    output logic [30:0]                       length_cm,
    output logic [13:0]                       car_speed_cms,
    output logic [9:0]                        foot_speed_cms,
    output logic [1:0]                        access_bits,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [elas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [elas_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic            push;
    logic            full;
    logic            empty;
    elas_pkg::item_t front_item;
    elas_pkg::item_t head_item;

    elas_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .full           (full),
        .start_lat_udeg (start_lat_udeg),
        .start_lon_udeg (start_lon_udeg),
        .end_lat_udeg   (end_lat_udeg),
        .end_lon_udeg   (end_lon_udeg),
        .road_kind      (road_kind),
        .car_allowed    (car_allowed),
        .foot_allowed   (foot_allowed),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cfg_ready      (cfg_ready),
        .busy           (busy),
        .push           (push),
        .item           (front_item)
    );

    elas_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .pop   (!empty),
        .rdata (head_item),
        .full  (full),
        .empty (empty)
    );

    elas_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (!empty),
        .item           (head_item),
        .done           (done),
        .length_cm      (length_cm),
        .car_speed_cms  (car_speed_cms),
        .foot_speed_cms (foot_speed_cms),
        .access_bits    (access_bits)
    );

endmodule

### rtl/core/elas_front.sv
// Front end: configuration registers, edge acceptance, latitude clamping and speed lookup.
`timescale 1ns / 1ps

module elas_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              full,
    input  logic signed [27:0]                start_lat_udeg,
    input  logic signed [28:0]                start_lon_udeg,
    input  logic signed [27:0]                end_lat_udeg,
    input  logic signed [28:0]                end_lon_udeg,
    input  logic [3:0]                        road_kind,
    input  logic                              car_allowed,
    input  logic                              foot_allowed,
    input  logic                              cfg_valid,
    input  logic [elas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [elas_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              cfg_ready,
    output logic                              busy,
    output logic                              push,
    output elas_pkg::item_t                   item
);

    localparam logic signed [27:0] LAT_MAX = 28'sd90000000;
    localparam logic signed [27:0] LAT_MIN = -28'sd90000000;

    logic [elas_pkg::SPEED_W-1:0] speed_reg [4];
    logic [elas_pkg::WALK_W-1:0]  walk_reg;

    logic signed [27:0] lat1_c;
    logic signed [27:0] lat2_c;
    logic signed [28:0] dlat;
    logic signed [29:0] dlon;

    assign cfg_ready = 1'b1;
    assign busy = full;
    assign push = start && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg[0] <= 14'd2778;
            speed_reg[1] <= 14'd2222;
            speed_reg[2] <= 14'd1667;
            speed_reg[3] <= 14'd1389;
            walk_reg <= 10'd140;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                elas_pkg::REG_MOTORWAY:    speed_reg[0] <= cfg_data;
                elas_pkg::REG_PRIMARY:     speed_reg[1] <= cfg_data;
                elas_pkg::REG_SECONDARY:   speed_reg[2] <= cfg_data;
                elas_pkg::REG_RESIDENTIAL: speed_reg[3] <= cfg_data;
                elas_pkg::REG_WALKING:     walk_reg <= cfg_data[elas_pkg::WALK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        lat1_c = start_lat_udeg;
        if (start_lat_udeg > LAT_MAX)
            lat1_c = LAT_MAX;
        else if (start_lat_udeg < LAT_MIN)
            lat1_c = LAT_MIN;
        lat2_c = end_lat_udeg;
        if (end_lat_udeg > LAT_MAX)
            lat2_c = LAT_MAX;
        else if (end_lat_udeg < LAT_MIN)
            lat2_c = LAT_MIN;

        dlat = 29'(lat2_c) - 29'(lat1_c);
        dlon = 30'(end_lon_udeg) - 30'(start_lon_udeg);

        item.lat1_mag = lat1_c[27] ? 28'(-lat1_c) : 28'(lat1_c);
        item.lat2_mag = lat2_c[27] ? 28'(-lat2_c) : 28'(lat2_c);
        item.dlat_mag = dlat[28] ? 28'(-dlat) : 28'(dlat);
        item.dlon = dlon;

        item.side.car_speed = '0;
        if (car_allowed && (road_kind inside {[4'd0:4'd3]}))
            item.side.car_speed = speed_reg[road_kind[1:0]];
        item.side.foot_speed = foot_allowed ? walk_reg : '0;
        item.side.access = {foot_allowed, car_allowed};
    end

endmodule

### rtl/core/elas_fifo.sv
// Short queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps

module elas_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  elas_pkg::item_t  wdata,
    input  logic             pop,
    output elas_pkg::item_t  rdata,
    output logic             full,
    output logic             empty
);

    elas_pkg::item_t mem_reg [elas_pkg::QDEPTH];

    logic [elas_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [elas_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [elas_pkg::QCNT_W-1:0] count_reg;
    logic [elas_pkg::QCNT_W-1:0] count_next;

    assign full = (count_reg == elas_pkg::QCNT_W'(elas_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 3'd1))
        else $error("queue count did not rise on push");
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 3'd1))
        else $error("queue count did not fall on pop");
`endif

endmodule

### rtl/core/elas_back.sv
// Back end: angle conversion, CORDIC sin/cos, haversine products, square roots, atan2, scaling.
`timescale 1ns / 1ps

module elas_back #(
    parameter int CORDIC_STEPS = 28
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  elas_pkg::item_t  item,
    output logic             done,
    output logic [30:0]      length_cm,
    output logic [13:0]      car_speed_cms,
    output logic [9:0]       foot_speed_cms,
    output logic [1:0]       access_bits
);

    localparam int SQ_STEPS = 31;
    localparam int LAT = 42 + 2 * CORDIC_STEPS;

    // PI_Q32 = PI_WHOLE * 703125 + 68955 and the divisors are 703125 << 10 or << 11, so
    // the angle is (m * PI_WHOLE + bias + floor(m * 68955 / 703125)) >> shift; the inner
    // floor is m times ceil(68955 * 2^48 / 703125), shifted down by 48
    localparam logic [14:0] PI_WHOLE = 15'd19190;
    localparam logic [44:0] PI_FRAC_RECIP = 45'd27604063316030;
    localparam logic [29:0] FULL_TURN = 30'd360000000;
    localparam logic [29:0] HALF_TURN = 30'd180000000;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [60:0] ONE_Q60 = 61'd1 << 60;
    localparam logic [30:0] ONE_Q30 = 31'd1 << 30;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [29:0] RADIUS_CM = 30'd637100000;

    function automatic logic [30:0] clamp_unit(input logic signed [33:0] v);
        logic [30:0] r;
        if (v[33])
            r = '0;
        else if (v[32:0] > 33'(ONE_Q30))
            r = ONE_Q30;
        else
            r = v[30:0];
        return r;
    endfunction

    // ---------------- valid and side-band delay line ----------------
    logic                  vld_reg [LAT];
    elas_pkg::side_t       side_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= item.side;
        for (int k = 1; k < LAT; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // ---------------- longitude fold and magnitudes ----------------
    logic [29:0] dlon_abs;
    logic [29:0] dlon_mod;
    logic [29:0] dlon_fold;
    logic [27:0] mag_reg [4];

    always_comb
    begin
        dlon_abs = item.dlon[29] ? 30'(-$signed(item.dlon)) : item.dlon;
        dlon_mod = (dlon_abs >= FULL_TURN) ? dlon_abs - FULL_TURN : dlon_abs;
        dlon_fold = (dlon_mod > HALF_TURN) ? FULL_TURN - dlon_mod : dlon_mod;
    end

    always_ff @(posedge clk)
    begin
        mag_reg[0] <= item.lat1_mag;
        mag_reg[1] <= item.lat2_mag;
        mag_reg[2] <= item.dlat_mag;
        mag_reg[3] <= dlon_fold[27:0];
    end

    // ---------------- microdegrees to Q30 radians ----------------
    logic [42:0] whole_reg [4];
    logic [50:0] frac_lo_reg [4];
    logic [49:0] frac_hi_reg [4];
    logic [42:0] part_reg [4];

    // ---------------- rotation CORDIC ----------------
    logic signed [33:0] rx_reg [4][CORDIC_STEPS];
    logic signed [33:0] ry_reg [4][CORDIC_STEPS];
    logic signed [33:0] rz_reg [4][CORDIC_STEPS];

    for (genvar ln = 0; ln < 4; ln++)
    begin : g_lane
        localparam int SHIFT = (ln < 2) ? 10 : 11;
        localparam logic [42:0] ROUND_BIAS = 43'd1 << (SHIFT - 1);

        logic [73:0] frac_sum;

        assign frac_sum = ({24'd0, frac_hi_reg[ln]} << 23) + {23'd0, frac_lo_reg[ln]};

        always_ff @(posedge clk)
        begin
            whole_reg[ln] <= mag_reg[ln] * PI_WHOLE;
            frac_lo_reg[ln] <= mag_reg[ln] * PI_FRAC_RECIP[22:0];
            frac_hi_reg[ln] <= mag_reg[ln] * PI_FRAC_RECIP[44:23];
            part_reg[ln] <= whole_reg[ln] + {17'd0, frac_sum[73:48]} + ROUND_BIAS;
        end

        for (genvar i = 0; i < CORDIC_STEPS; i++)
        begin : g_rot
            logic signed [33:0] x_in;
            logic signed [33:0] y_in;
            logic signed [33:0] z_in;
            logic signed [33:0] step;
            if (i == 0)
            begin : g_first
                assign x_in = GAIN_Q30;
                assign y_in = '0;
                assign z_in = $signed({3'd0, 31'(part_reg[ln] >> SHIFT)});
            end
            else
            begin : g_rest
                assign x_in = rx_reg[ln][i-1];
                assign y_in = ry_reg[ln][i-1];
                assign z_in = rz_reg[ln][i-1];
            end
            assign step = $signed({3'd0, elas_pkg::atan_q30(i)});
            always_ff @(posedge clk)
            begin
                if (!z_in[33])
                begin
                    rx_reg[ln][i] <= x_in - (y_in >>> i);
                    ry_reg[ln][i] <= y_in + (x_in >>> i);
                    rz_reg[ln][i] <= z_in - step;
                end
                else
                begin
                    rx_reg[ln][i] <= x_in + (y_in >>> i);
                    ry_reg[ln][i] <= y_in - (x_in >>> i);
                    rz_reg[ln][i] <= z_in + step;
                end
            end
        end
    end

    // ---------------- haversine term a ----------------
    logic [30:0] c1, c2, s1, s2;
    logic [61:0] c1c2_reg, t_reg;
    logic [61:0] s1sq_reg [4];
    logic [30:0] s2_reg [2];
    logic [30:0] cc;
    logic [33:0] u;
    logic [49:0] ulo_reg;
    logic [48:0] uhi_reg;
    logic [60:0] term_reg;
    logic [62:0] asum;
    logic [60:0] a_reg;
    logic [60:0] va_reg, vb_reg;

    assign c1 = clamp_unit(rx_reg[0][CORDIC_STEPS-1]);
    assign c2 = clamp_unit(rx_reg[1][CORDIC_STEPS-1]);
    assign s1 = clamp_unit(ry_reg[2][CORDIC_STEPS-1]);
    assign s2 = clamp_unit(ry_reg[3][CORDIC_STEPS-1]);
    assign cc = 31'((c1c2_reg + (62'd1 << 29)) >> 30);
    assign u = 34'((t_reg + (62'd1 << 26)) >> 27);
    assign asum = {2'd0, s1sq_reg[3][60:0]} + {2'd0, term_reg};

    always_ff @(posedge clk)
    begin
        c1c2_reg <= c1 * c2;
        s1sq_reg[0] <= s1 * s1;
        s2_reg[0] <= s2;

        t_reg <= cc * s2_reg[0];
        s1sq_reg[1] <= s1sq_reg[0];
        s2_reg[1] <= s2_reg[0];

        ulo_reg <= u * s2_reg[1][15:0];
        uhi_reg <= u * s2_reg[1][30:16];
        s1sq_reg[2] <= s1sq_reg[1];

        term_reg <= 61'((({16'd0, uhi_reg} << 16) + {15'd0, ulo_reg} + 65'd4) >> 3);
        s1sq_reg[3] <= s1sq_reg[2];

        a_reg <= (asum > 63'(ONE_Q60)) ? ONE_Q60 : asum[60:0];

        va_reg <= a_reg;
        vb_reg <= ONE_Q60 - a_reg;
    end

    // ---------------- square roots, lane 0 of a, lane 1 of 1 - a ----------------
    logic [60:0] sv_reg [2][SQ_STEPS];
    logic [61:0] sr_reg [2][SQ_STEPS];

    for (genvar q = 0; q < 2; q++)
    begin : g_sqrt
        for (genvar j = 0; j < SQ_STEPS; j++)
        begin : g_step
            logic [60:0] v_in;
            logic [61:0] r_in;
            logic [61:0] bitv;
            logic [61:0] trial;
            if (j == 0)
            begin : g_first
                assign v_in = (q == 0) ? va_reg : vb_reg;
                assign r_in = '0;
            end
            else
            begin : g_rest
                assign v_in = sv_reg[q][j-1];
                assign r_in = sr_reg[q][j-1];
            end
            assign bitv = 62'd1 << (60 - 2 * j);
            assign trial = r_in + bitv;
            always_ff @(posedge clk)
            begin
                if ({1'b0, v_in} >= trial)
                begin
                    sv_reg[q][j] <= 61'({1'b0, v_in} - trial);
                    sr_reg[q][j] <= (r_in >> 1) + bitv;
                end
                else
                begin
                    sv_reg[q][j] <= v_in;
                    sr_reg[q][j] <= r_in >> 1;
                end
            end
        end
    end

    // ---------------- vectoring CORDIC, atan2(sqrt(a), sqrt(1-a)) ----------------
    logic signed [33:0] vx_reg [CORDIC_STEPS];
    logic signed [33:0] vy_reg [CORDIC_STEPS];
    logic signed [33:0] vz_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        logic signed [33:0] x_in;
        logic signed [33:0] y_in;
        logic signed [33:0] z_in;
        logic signed [33:0] step;
        if (i == 0)
        begin : g_first
            assign x_in = $signed({3'd0, sr_reg[1][SQ_STEPS-1][30:0]});
            assign y_in = $signed({3'd0, sr_reg[0][SQ_STEPS-1][30:0]});
            assign z_in = '0;
        end
        else
        begin : g_rest
            assign x_in = vx_reg[i-1];
            assign y_in = vy_reg[i-1];
            assign z_in = vz_reg[i-1];
        end
        assign step = $signed({3'd0, elas_pkg::atan_q30(i)});
        always_ff @(posedge clk)
        begin
            if (!y_in[33])
            begin
                vx_reg[i] <= x_in + (y_in >>> i);
                vy_reg[i] <= y_in - (x_in >>> i);
                vz_reg[i] <= z_in + step;
            end
            else
            begin
                vx_reg[i] <= x_in - (y_in >>> i);
                vy_reg[i] <= y_in + (x_in >>> i);
                vz_reg[i] <= z_in - step;
            end
        end
    end

    // ---------------- scale by the radius ----------------
    logic signed [33:0] z_fin;
    logic [30:0] z_clamp;
    logic [60:0] prod_reg;
    logic [30:0] len_reg;

    assign z_fin = vz_reg[CORDIC_STEPS-1];

    always_comb
    begin
        if (z_fin[33])
            z_clamp = '0;
        else if (z_fin[32:0] > 33'(HALF_PI_Q30))
            z_clamp = HALF_PI_Q30;
        else
            z_clamp = z_fin[30:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= z_clamp * RADIUS_CM;
        len_reg <= 31'((prod_reg + (61'd1 << 28)) >> 29);
    end

    assign done = vld_reg[LAT-1];
    assign length_cm = len_reg;
    assign car_speed_cms = side_reg[LAT-1].car_speed;
    assign foot_speed_cms = side_reg[LAT-1].foot_speed;
    assign access_bits = side_reg[LAT-1].access;

endmodule

### tb/edge_length_and_speed_unit_test.sv
// Self-checking testbench for the edge length and speed unit.
`timescale 1ns / 1ps

module edge_length_and_speed_unit_test;

    localparam longint unsigned PI_Q32 = 64'd13493037705;
    localparam longint GAIN_Q30 = 64'd652032874;
    localparam longint ONE_Q30 = 64'd1 << 30;
    localparam longint HALF_PI_Q30 = 64'd1686629713;
    localparam int STEPS = 28;
    localparam int SETTLE_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [elas_pkg::CFG_IDX_W-1:0] FIRST_UNUSED_IDX =
        elas_pkg::REG_WALKING + 3'd1;
    localparam logic [elas_pkg::CFG_IDX_W-1:0] MID_UNUSED_IDX =
        elas_pkg::REG_WALKING + 3'd2;
    localparam logic [elas_pkg::CFG_IDX_W-1:0] LAST_UNUSED_IDX = '1;

    typedef struct {
        logic signed [27:0] lat1;
        logic signed [28:0] lon1;
        logic signed [27:0] lat2;
        logic signed [28:0] lon2;
        logic [3:0]         kind;
        logic               car;
        logic               foot;
    } edge_t;

    typedef struct {
        logic [30:0] len;
        logic [13:0] car_spd;
        logic [9:0]  foot_spd;
        logic [1:0]  acc;
    } edge_res_t;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [27:0] start_lat_udeg = '0;
    logic signed [28:0] start_lon_udeg = '0;
    logic signed [27:0] end_lat_udeg = '0;
    logic signed [28:0] end_lon_udeg = '0;
    logic [3:0] road_kind = '0;
    logic car_allowed = 0;
    logic foot_allowed = 0;
    logic done;
    logic [30:0] length_cm;
    logic [13:0] car_speed_cms;
    logic [9:0] foot_speed_cms;
    logic [1:0] access_bits;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [elas_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [elas_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    edge_length_and_speed_unit DUT (.*);

    always #5 clk = ~clk;

    edge_t pending_edges[$];
    edge_res_t expected_res[$];
    edge_t cur_edge;
    logic [13:0] class_speed[4];
    logic [9:0] walk_speed;
    int sender_idle_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // ---------------- fixed-point haversine predictor ----------------
    function automatic longint atan_step(int i);
        case (i)
            0: return 843314857;
            1: return 64'h1DAC6705;
            2: return 64'h0FADBAFC;
            3: return 64'h07F56EA6;
            4: return 64'h03FEAB76;
            5: return 64'h01FFD55B;
            6: return 64'h00FFFAAA;
            7: return 64'h007FFF55;
            8: return 64'h003FFFEA;
            9: return 64'h001FFFFD;
            10: return 1048576;
            default: return (i <= 30) ? (64'd1 << (30 - i)) : 0;
        endcase
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint udeg_rad(longint unsigned mag, longint unsigned div);
        return longint'((mag * PI_Q32 + div / 2) / div);
    endfunction

    function automatic void sin_cos(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = GAIN_Q30;
        y = 0;
        z = ang;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = clampl(x, 0, ONE_Q30);
        s = clampl(y, 0, ONE_Q30);
    endfunction

    function automatic longint arc_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        return clampl(z, 0, HALF_PI_Q30);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [30:0] great_circle_cm(edge_t e);
        longint lat1, lat2, dlat, dlon, c1, c2, s1, s2, junk, z;
        longint unsigned cc, t, u, term, a;
        lat1 = clampl(longint'(e.lat1), -90000000, 90000000);
        lat2 = clampl(longint'(e.lat2), -90000000, 90000000);
        dlat = lat2 - lat1;
        dlon = (longint'(e.lon2) - longint'(e.lon1)) % 360000000;
        if (dlon > 180000000) dlon -= 360000000;
        if (dlon < -180000000) dlon += 360000000;
        sin_cos(udeg_rad(lat1 < 0 ? -lat1 : lat1, 720000000), c1, junk);
        sin_cos(udeg_rad(lat2 < 0 ? -lat2 : lat2, 720000000), c2, junk);
        sin_cos(udeg_rad(dlat < 0 ? -dlat : dlat, 1440000000), junk, s1);
        sin_cos(udeg_rad(dlon < 0 ? -dlon : dlon, 1440000000), junk, s2);
        cc = (longint'(c1) * c2 + (64'd1 << 29)) >> 30;
        t = cc * longint'(s2);
        u = (t + (64'd1 << 26)) >> 27;
        term = (u * longint'(s2) + 4) >> 3;
        a = longint'(s1) * s1 + term;
        if (a > (64'd1 << 60))
            a = 64'd1 << 60;
        z = arc_angle(longint'(int_sqrt((64'd1 << 60) - a)), longint'(int_sqrt(a)));
        return 31'((longint'(z) * 637100000 + (64'd1 << 28)) >> 29);
    endfunction

    function automatic edge_res_t predict_edge(edge_t e);
        edge_res_t r;
        r.len = great_circle_cm(e);
        r.car_spd = (e.car && e.kind < 4) ? class_speed[e.kind[1:0]] : '0;
        r.foot_spd = e.foot ? walk_speed : '0;
        r.acc = {e.foot, e.car};
        return r;
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk)
    begin
        edge_t nxt;
        logic drive;
        if (start && !busy)
        begin
            expected_res = {expected_res, predict_edge(cur_edge)};
            void'(pending_edges.pop_front());
        end
        drive = pending_edges.size() > 0 && $urandom_range(99) >= sender_idle_pct;
        if (drive)
        begin
            nxt = pending_edges[0];
            cur_edge <= nxt;
            start_lat_udeg <= nxt.lat1;
            start_lon_udeg <= nxt.lon1;
            end_lat_udeg <= nxt.lat2;
            end_lon_udeg <= nxt.lon2;
            road_kind <= nxt.kind;
            car_allowed <= nxt.car;
            foot_allowed <= nxt.foot;
        end
        start <= drive;
    end

    // ---------------- register shadow ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_speed[0] <= 14'd2778;
            class_speed[1] <= 14'd2222;
            class_speed[2] <= 14'd1667;
            class_speed[3] <= 14'd1389;
            walk_speed <= 10'd140;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                elas_pkg::REG_MOTORWAY, elas_pkg::REG_PRIMARY, elas_pkg::REG_SECONDARY,
                elas_pkg::REG_RESIDENTIAL:
                    class_speed[cfg_index[1:0]] <= cfg_data;
                elas_pkg::REG_WALKING: walk_speed <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        edge_res_t exp_r;
        if (rst_n && done)
        begin
            if (expected_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: len %0d car %0d foot %0d acc %0d",
                             length_cm, car_speed_cms, foot_speed_cms, access_bits);
            end
            else
            begin
                exp_r = expected_res.pop_front();
                if (exp_r.len !== length_cm || exp_r.car_spd !== car_speed_cms ||
                    exp_r.foot_spd !== foot_speed_cms || exp_r.acc !== access_bits)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 exp_r.len, exp_r.car_spd, exp_r.foot_spd, exp_r.acc,
                                 length_cm, car_speed_cms, foot_speed_cms, access_bits);
                end
            end
        end
    end

    // watchdog: cycles with no transaction of any kind
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic edge_t mk_edge(int la1, int lo1, int la2, int lo2, int k, bit c, bit f);
        edge_t e;
        e.lat1 = 28'(la1);
        e.lon1 = 29'(lo1);
        e.lat2 = 28'(la2);
        e.lon2 = 29'(lo2);
        e.kind = 4'(k);
        e.car = c;
        e.foot = f;
        return e;
    endfunction

    function automatic int rand_span(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    function automatic edge_t rand_edge();
        edge_t e;
        int mode;
        mode = $urandom_range(9);
        e.kind = ($urandom_range(3) != 0) ? 4'($urandom_range(3)) : 4'($urandom);
        e.car = 1'($urandom);
        e.foot = 1'($urandom);
        if (mode == 0)
        begin
            // raw bit patterns, poles exceeded and longitudes wrapping
            e.lat1 = 28'($urandom); e.lon1 = 29'($urandom);
            e.lat2 = 28'($urandom); e.lon2 = 29'($urandom);
        end
        else if (mode <= 5)
        begin
            // short road-like edge
            e.lat1 = 28'(rand_span(89000000));
            e.lon1 = 29'(rand_span(179000000));
            e.lat2 = 28'(int'(e.lat1) + rand_span(int'($urandom_range(1, 500000))));
            e.lon2 = 29'(int'(e.lon1) + rand_span(int'($urandom_range(1, 500000))));
        end
        else
        begin
            e.lat1 = 28'(rand_span(90000000)); e.lon1 = 29'(rand_span(180000000));
            e.lat2 = 28'(rand_span(90000000)); e.lon2 = 29'(rand_span(180000000));
        end
        return e;
    endfunction

    task automatic add_edge(edge_t e);
        pending_edges = {pending_edges, e};
    endtask

    task automatic settle();
        while (pending_edges.size() != 0 || expected_res.size() != 0 || start)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [elas_pkg::CFG_IDX_W-1:0] idx,
                             logic [elas_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [13:0] m, logic [13:0] p, logic [13:0] s,
                             logic [13:0] r, logic [13:0] w);
        write_reg(elas_pkg::REG_MOTORWAY, m);
        write_reg(elas_pkg::REG_PRIMARY, p);
        write_reg(elas_pkg::REG_SECONDARY, s);
        write_reg(elas_pkg::REG_RESIDENTIAL, r);
        write_reg(elas_pkg::REG_WALKING, w);
    endtask

    task automatic run_random(int n, int idle);
        sender_idle_pct = idle;
        repeat (n) add_edge(rand_edge());
        settle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed edges under reset register values
        add_edge(mk_edge(0, 0, 0, 0, 0, 1, 1));
        add_edge(mk_edge(90000000, 0, -90000000, 0, 1, 1, 0));
        add_edge(mk_edge(0, 0, 0, 180000000, 2, 0, 1));
        add_edge(mk_edge(0, -180000000, 0, 180000000, 3, 1, 1));
        add_edge(mk_edge(0, -95000000, 0, 95000000, 3, 1, 0));
        add_edge(mk_edge(134217727, 268435455, -134217728, -268435456, 0, 1, 1));
        add_edge(mk_edge(-134217728, -268435456, 134217727, 268435455, 4, 1, 1));
        add_edge(mk_edge(45000000, 7000000, 45000000, 7000000, 15, 0, 0));
        add_edge(mk_edge(52520008, 13404954, 52520108, 13405054, 1, 1, 1));
        add_edge(mk_edge(-33868820, 151209296, 51507351, -127758, 2, 1, 1));
        add_edge(mk_edge(89999999, -180000000, 89999999, 0, 0, 0, 1));
        add_edge(mk_edge(0, 0, 1, 1, 7, 1, 0));
        for (int k = 0; k < 16; k++)
            add_edge(mk_edge(10000000, 20000000, 10001000, 19999000,
                             k, k[0] | (k < 4), k[1]));
        settle();

        write_all(14'd0, 14'd0, 14'd0, 14'd0, 14'd0);
        write_reg(FIRST_UNUSED_IDX, 14'h3FFF);
        run_random(350, 0);

        write_all(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
        write_reg(LAST_UNUSED_IDX, 14'd0);
        run_random(400, 76);

        write_all(14'($urandom_range(10000)), 14'($urandom_range(10000)),
                  14'($urandom), 14'($urandom_range(10000)), 14'($urandom_range(1000)));
        run_random(400, 8);

        write_all(14'd10000, 14'd1, 14'($urandom), 14'd9999, 14'd1000);
        write_reg(MID_UNUSED_IDX, 14'($urandom));
        run_random(480, 0);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
